// ----- rtl/med3_pkg.sv -----
`default_nettype none

package med3_pkg;

    // Fixed widths of the channel words
    localparam int PIX_W = 16;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd5;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags of one pixel, decided when it is taken
    typedef struct packed {
        logic row_last;
        logic col_last;
        logic i_ge1;
        logic i_ge2;
        logic j_ge1;
        logic j_ge2;
    } pos_flags_t;

endpackage

`default_nettype wire

// ----- rtl/med3_ifs.sv -----
`default_nettype none

interface med3_pix_if;
    logic                       valid;
    logic                       ready;
    logic [med3_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface med3_res_if;
    logic                       valid;
    logic                       ready;
    logic [med3_pkg::POS_W-1:0] out_row;
    logic [med3_pkg::POS_W-1:0] out_col;
    logic [med3_pkg::PIX_W-1:0] eroded_value;
    logic [med3_pkg::PIX_W-1:0] dilated_value;
    logic                       frame_last;

    modport source (output valid, output out_row, output out_col, output eroded_value,
                    output dilated_value, output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input eroded_value,
                    input dilated_value, input frame_last, output ready);
endinterface

interface med3_cfg_if;
    logic                       valid;
    logic                       ready;
    med3_pkg::cfg_reg_t         index;
    logic [med3_pkg::CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/med3_line_window.sv -----
`default_nettype none

module med3_line_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int COL_BITS   = 10,
    parameter int ROW_BITS   = 10
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   take,
    input  wire logic [PIXEL_BITS-1:0]  pix,
    input  wire logic [ROW_BITS-1:0]    row,
    input  wire logic [COL_BITS-1:0]    col,
    input  wire med3_pkg::pos_flags_t   flags,
    output logic                        win_valid,
    output logic [PIXEL_BITS-1:0]       win [9],
    output logic [ROW_BITS-1:0]         win_row,
    output logic [COL_BITS-1:0]         win_col,
    output med3_pkg::pos_flags_t        win_flags
);

    // word layout: upper half holds row i-2, lower half row i-1
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] rd_data_reg;

    logic                    s1_valid_reg;
    logic [PIXEL_BITS-1:0]   s1_pix_reg;
    logic [ROW_BITS-1:0]     s1_row_reg;
    logic [COL_BITS-1:0]     s1_col_reg;
    med3_pkg::pos_flags_t    s1_flags_reg;

    logic                    s2_valid_reg;
    logic [ROW_BITS-1:0]     s2_row_reg;
    logic [COL_BITS-1:0]     s2_col_reg;
    med3_pkg::pos_flags_t    s2_flags_reg;
    logic [2*PIXEL_BITS-1:0] s2_wdata_reg;

    logic [PIXEL_BITS-1:0]   window_reg [9];

    logic                    fwd;
    logic [2*PIXEL_BITS-1:0] line_word;
    logic [PIXEL_BITS-1:0]   above2;
    logic [PIXEL_BITS-1:0]   above1;
    logic                    wr_en;
    logic [2*PIXEL_BITS-1:0] wr_data;

    // the word written back by the previous pixel is not yet visible to the read
    assign fwd       = s2_valid_reg && (s2_col_reg == s1_col_reg);
    assign line_word = fwd ? s2_wdata_reg : rd_data_reg;
    assign above2    = line_word[2*PIXEL_BITS-1:PIXEL_BITS];
    assign above1    = line_word[PIXEL_BITS-1:0];
    assign wr_en     = adv && s1_valid_reg;
    assign wr_data   = {above1, s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_data_reg <= line_mem[col];
        end
        if (wr_en)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg   <= pix;
            s1_row_reg   <= row;
            s1_col_reg   <= col;
            s1_flags_reg <= flags;
        end
        if (wr_en)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
            s2_wdata_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= above2;
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= above1;
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= s1_pix_reg;
        end
    end

    assign win_valid = s2_valid_reg;
    assign win       = window_reg;
    assign win_row   = s2_row_reg;
    assign win_col   = s2_col_reg;
    assign win_flags = s2_flags_reg;

endmodule

`default_nettype wire

// ----- rtl/med3_reduce.sv -----
`default_nettype none

module med3_reduce #(
    parameter int PIXEL_BITS = 16,
    parameter int COL_BITS   = 10,
    parameter int ROW_BITS   = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       win_valid,
    input  wire logic [PIXEL_BITS-1:0]      win [9],
    input  wire logic [ROW_BITS-1:0]        win_row,
    input  wire logic [COL_BITS-1:0]        win_col,
    input  wire med3_pkg::pos_flags_t       win_flags,
    output logic                            adv,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [med3_pkg::POS_W-1:0]      out_row,
    output logic [med3_pkg::POS_W-1:0]      out_col,
    output logic [med3_pkg::PIX_W-1:0]      eroded_value,
    output logic [med3_pkg::PIX_W-1:0]      dilated_value,
    output logic                            frame_last
);

    localparam logic [PIXEL_BITS-1:0] ONES = '1;

    function automatic logic [PIXEL_BITS-1:0] pmin(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pmax(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // pending results: bit0 up/left, bit1 up/right, bit2 low/left, bit3 low/right
    logic [3:0]            pend_reg;
    logic [3:0]            pend_next;
    logic [ROW_BITS-1:0]   s3_row_reg;
    logic [COL_BITS-1:0]   s3_col_reg;
    logic                  s3_j_ge1_reg;
    logic                  s3_j_ge2_reg;
    logic [PIXEL_BITS-1:0] cmin_up_reg [3];
    logic [PIXEL_BITS-1:0] cmax_up_reg [3];
    logic [PIXEL_BITS-1:0] cmin_lo_reg [3];
    logic [PIXEL_BITS-1:0] cmax_lo_reg [3];

    logic [PIXEL_BITS-1:0] cmin_up [3];
    logic [PIXEL_BITS-1:0] cmax_up [3];
    logic [PIXEL_BITS-1:0] cmin_lo [3];
    logic [PIXEL_BITS-1:0] cmax_lo [3];
    logic [3:0]            new_pend;

    logic                          out_valid_reg;
    logic [med3_pkg::POS_W-1:0]    out_row_reg;
    logic [med3_pkg::POS_W-1:0]    out_col_reg;
    logic [med3_pkg::PIX_W-1:0]    eroded_reg;
    logic [med3_pkg::PIX_W-1:0]    dilated_reg;
    logic                          frame_last_reg;

    logic [3:0]            low_bit;
    logic                  load;
    logic                  sel_up;
    logic                  sel_right;
    logic [PIXEL_BITS-1:0] mn_src [3];
    logic [PIXEL_BITS-1:0] mx_src [3];
    logic [PIXEL_BITS-1:0] mn0;
    logic [PIXEL_BITS-1:0] mn1;
    logic [PIXEL_BITS-1:0] mx0;
    logic [PIXEL_BITS-1:0] mx1;
    logic [PIXEL_BITS-1:0] res_min;
    logic [PIXEL_BITS-1:0] res_max;
    logic [ROW_BITS-1:0]   res_row;
    logic [COL_BITS-1:0]   res_col;

    // per-column reduction; upper set is for row i-1, lower set for row i
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cmin_up[c] = pmin(pmin(win_flags.i_ge2 ? win[c] : ONES, win[3+c]), win[6+c]);
            cmax_up[c] = pmax(pmax(win_flags.i_ge2 ? win[c] : '0, win[3+c]), win[6+c]);
            cmin_lo[c] = pmin(win_flags.i_ge1 ? win[3+c] : ONES, win[6+c]);
            cmax_lo[c] = pmax(win_flags.i_ge1 ? win[3+c] : '0, win[6+c]);
        end
        new_pend[0] = win_flags.i_ge1 && win_flags.j_ge1;
        new_pend[1] = win_flags.i_ge1 && win_flags.col_last;
        new_pend[2] = win_flags.row_last && win_flags.j_ge1;
        new_pend[3] = win_flags.row_last && win_flags.col_last;
    end

    assign low_bit   = pend_reg & (~pend_reg + 4'd1);
    assign load      = (pend_reg != 4'd0) && (!out_valid_reg || out_ready);
    assign adv       = (pend_reg == 4'd0) || (((pend_reg & (pend_reg - 4'd1)) == 4'd0) && load);
    assign sel_up    = low_bit[0] || low_bit[1];
    assign sel_right = low_bit[1] || low_bit[3];

    always_comb
    begin
        if (adv)
        begin
            pend_next = win_valid ? new_pend : 4'd0;
        end
        else if (load)
        begin
            pend_next = pend_reg & ~low_bit;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 4'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && win_valid)
        begin
            s3_row_reg   <= win_row;
            s3_col_reg   <= win_col;
            s3_j_ge1_reg <= win_flags.j_ge1;
            s3_j_ge2_reg <= win_flags.j_ge2;
            cmin_up_reg  <= cmin_up;
            cmax_up_reg  <= cmax_up;
            cmin_lo_reg  <= cmin_lo;
            cmax_lo_reg  <= cmax_lo;
        end
    end

    // combine the three columns of the selected result, clipped at the frame edges
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mn_src[c] = sel_up ? cmin_up_reg[c] : cmin_lo_reg[c];
            mx_src[c] = sel_up ? cmax_up_reg[c] : cmax_lo_reg[c];
        end
        mn0 = (!sel_right && s3_j_ge2_reg) ? mn_src[0] : ONES;
        mx0 = (!sel_right && s3_j_ge2_reg) ? mx_src[0] : '0;
        mn1 = (sel_right && !s3_j_ge1_reg) ? ONES : mn_src[1];
        mx1 = (sel_right && !s3_j_ge1_reg) ? '0 : mx_src[1];
        res_min = pmin(pmin(mn0, mn1), mn_src[2]);
        res_max = pmax(pmax(mx0, mx1), mx_src[2]);
        res_row = sel_up ? (s3_row_reg - ROW_BITS'(1)) : s3_row_reg;
        res_col = sel_right ? s3_col_reg : (s3_col_reg - COL_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg    <= med3_pkg::POS_W'(res_row);
            out_col_reg    <= med3_pkg::POS_W'(res_col);
            eroded_reg     <= med3_pkg::PIX_W'(res_min);
            dilated_reg    <= med3_pkg::PIX_W'(res_max);
            frame_last_reg <= low_bit[3];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign eroded_value  = eroded_reg;
    assign dilated_value = dilated_reg;
    assign frame_last    = frame_last_reg;

endmodule

`default_nettype wire

// ----- rtl/morph_erode_dilate_3x3.sv -----
// 3x3 grayscale erosion and dilation on a raster-order pixel stream.
// Channels: pixel (sink) takes one word per sample; result (source) gives
// row, column, min, max and a frame_last mark for each pixel; cfg (sink)
// writes frame_width (index 0) and frame_height (index 1), always ready.
// Sizes are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT.
// A pixel releases up to four results, in raster order, as soon as its clipped
// window is complete; frame_last marks the bottom-right pixel's word.
// A pixel's results pass the s1, s2/window, s3 and output registers in turn.
// Throughput is one pixel per cycle while each pixel releases at most one
// result and the receiver is ready; the output register gives one word per
// cycle, so a pixel that releases 2 or 4 results holds the input until all
// but its last are loaded. The two previous rows sit in one line memory,
// single-port-per-side (MAX_WIDTH words of two samples), read on input and
// written back from s1, forwarding when consecutive pixels share a column.
// Reset clears the pipeline, the window and the position and sets both sizes
// to 5; the line memory needs no clearing.
// When the receiver stalls, the output word holds, the pipeline fills and
// pixel.ready drops; nothing is lost.
`default_nettype none

module morph_erode_dilate_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    med3_pix_if.sink    pixel,
    med3_res_if.source  result,
    med3_cfg_if.sink    cfg
);

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [med3_pkg::CFG_W-1:0] width_reg;
    logic [med3_pkg::CFG_W-1:0] height_reg;
    logic [COL_BITS-1:0]        col_pos_reg;
    logic [COL_BITS-1:0]        col_pos_next;
    logic [ROW_BITS-1:0]        row_pos_reg;
    logic [ROW_BITS-1:0]        row_pos_next;

    logic [COL_BITS-1:0]        col_end;
    logic [ROW_BITS-1:0]        row_end;
    logic                       wrap;
    logic [COL_BITS-1:0]        cur_col;
    logic [ROW_BITS-1:0]        cur_row;
    med3_pkg::pos_flags_t       flags;
    logic                       adv;
    logic                       take;
    logic [PIXEL_BITS-1:0]      pix;

    logic                       win_valid;
    logic [PIXEL_BITS-1:0]      win [9];
    logic [ROW_BITS-1:0]        win_row;
    logic [COL_BITS-1:0]        win_col;
    med3_pkg::pos_flags_t       win_flags;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= med3_pkg::SIZE_RESET;
            height_reg <= med3_pkg::SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                med3_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg.data;
                med3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // last column and row index after clamping
    always_comb
    begin
        if (width_reg == '0)
        begin
            col_end = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            col_end = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            col_end = COL_BITS'(width_reg - 1'b1);
        end

        if (height_reg == '0)
        begin
            row_end = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            row_end = ROW_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_end = ROW_BITS'(height_reg - 1'b1);
        end
    end

    // a position left outside a shrunk frame restarts at the origin
    assign wrap    = (col_pos_reg > col_end) || (row_pos_reg > row_end);
    assign cur_col = wrap ? '0 : col_pos_reg;
    assign cur_row = wrap ? '0 : row_pos_reg;

    always_comb
    begin
        flags.row_last = (cur_row == row_end);
        flags.col_last = (cur_col == col_end);
        flags.i_ge1    = (cur_row != '0);
        flags.i_ge2    = (cur_row > ROW_BITS'(1));
        flags.j_ge1    = (cur_col != '0);
        flags.j_ge2    = (cur_col > COL_BITS'(1));
    end

    assign take        = pixel.valid && adv;
    assign pixel.ready = adv;
    assign pix         = PIXEL_BITS'(pixel.pixel_value);

    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (take)
        begin
            if (flags.col_last)
            begin
                col_pos_next = '0;
                row_pos_next = flags.row_last ? '0 : (cur_row + ROW_BITS'(1));
            end
            else
            begin
                col_pos_next = cur_col + COL_BITS'(1);
                row_pos_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    med3_line_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_line_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .take      (take),
        .pix       (pix),
        .row       (cur_row),
        .col       (cur_col),
        .flags     (flags),
        .win_valid (win_valid),
        .win       (win),
        .win_row   (win_row),
        .win_col   (win_col),
        .win_flags (win_flags)
    );

    med3_reduce #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (win_valid),
        .win           (win),
        .win_row       (win_row),
        .win_col       (win_col),
        .win_flags     (win_flags),
        .adv           (adv),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_row       (result.out_row),
        .out_col       (result.out_col),
        .eroded_value  (result.eroded_value),
        .dilated_value (result.dilated_value),
        .frame_last    (result.frame_last)
    );

endmodule

`default_nettype wire

// ----- tb/minmax_checker.sv -----
module minmax_checker (
    input  logic clk,
    input  logic rst_n,
    med3_pix_if  pixel,
    med3_res_if  result,
    med3_cfg_if  cfg,
    output int   fail_count,
    output int   words_due,
    output int   words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX = 1024;

    typedef struct packed {
        logic [med3_pkg::POS_W-1:0] row;
        logic [med3_pkg::POS_W-1:0] col;
        logic [med3_pkg::PIX_W-1:0] lo;
        logic [med3_pkg::PIX_W-1:0] hi;
        logic                       last;
    } minmax_word_t;

    // slot 0 holds row i-2, slot 1 holds row i-1
    logic [med3_pkg::PIX_W-1:0] line_mem [0:2*SIDE_MAX-1];
    logic [med3_pkg::PIX_W-1:0] win [0:8];
    int                         row_pos;
    int                         col_pos;
    logic [med3_pkg::CFG_W-1:0] width_reg;
    logic [med3_pkg::CFG_W-1:0] height_reg;
    minmax_word_t               minmax_due [$];

    initial
    begin
        fail_count    = 0;
        words_checked = 0;
    end

    function automatic int clamp_size(input logic [med3_pkg::CFG_W-1:0] v, input int top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        fail_count++;
    endtask

    // Advance the window by one pixel and queue the words it completes.
    task automatic take_pixel(input logic [med3_pkg::PIX_W-1:0] px);
        int                         w, h, i, j, nr, nc, ri, ci, r, c, ir, ic;
        int                         orows [2];
        int                         ocols [2];
        logic [med3_pkg::PIX_W-1:0] a, b, v, lo, hi;
        minmax_word_t               wd;
        w = clamp_size(width_reg, SIDE_MAX);
        h = clamp_size(height_reg, SIDE_MAX);
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        i = row_pos;
        j = col_pos;
        a = line_mem[j];
        b = line_mem[SIDE_MAX + j];
        line_mem[j]            = b;
        line_mem[SIDE_MAX + j] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = a;
        win[5] = b;
        win[8] = px;

        nr = 0;
        nc = 0;
        if (i >= 1)
        begin
            orows[nr] = i - 1;
            nr++;
        end
        if (i == h - 1)
        begin
            orows[nr] = i;
            nr++;
        end
        if (j >= 1)
        begin
            ocols[nc] = j - 1;
            nc++;
        end
        if (j == w - 1)
        begin
            ocols[nc] = j;
            nc++;
        end

        for (ri = 0; ri < nr; ri++)
        begin
            for (ci = 0; ci < nc; ci++)
            begin
                lo = '1;
                hi = '0;
                for (r = 0; r < 3; r++)
                begin
                    ir = i - 2 + r;
                    if (ir < 0 || ir < orows[ri] - 1 || ir > orows[ri] + 1)
                        continue;
                    for (c = 0; c < 3; c++)
                    begin
                        ic = j - 2 + c;
                        if (ic < 0 || ic < ocols[ci] - 1 || ic > ocols[ci] + 1)
                            continue;
                        v = win[r*3 + c];
                        if (v < lo)
                            lo = v;
                        if (v > hi)
                            hi = v;
                    end
                end
                wd.row  = med3_pkg::POS_W'(orows[ri]);
                wd.col  = med3_pkg::POS_W'(ocols[ci]);
                wd.lo   = lo;
                wd.hi   = hi;
                wd.last = (orows[ri] == h - 1) && (ocols[ci] == w - 1);
                minmax_due.push_back(wd);
            end
        end

        if (j == w - 1)
        begin
            col_pos = 0;
            row_pos = (i == h - 1) ? 0 : ((row_pos + 1) & 'h3FF);
        end
        else
        begin
            col_pos = (col_pos + 1) & 'h3FF;
        end
    endtask

    task automatic check_word();
        minmax_word_t got;
        minmax_word_t want;
        got.row  = result.out_row;
        got.col  = result.out_col;
        got.lo   = result.eroded_value;
        got.hi   = result.dilated_value;
        got.last = result.frame_last;
        if (minmax_due.size() == 0)
        begin
            report_mismatch($sformatf("word with nothing due: (%0d,%0d) min %0d max %0d last %0b",
                                      got.row, got.col, got.lo, got.hi, got.last));
        end
        else
        begin
            want = minmax_due.pop_front();
            words_checked++;
            if (got !== want)
                report_mismatch($sformatf(
                    "got (%0d,%0d) min %0d max %0d last %0b, want (%0d,%0d) min %0d max %0d last %0b",
                    got.row, got.col, got.lo, got.hi, got.last,
                    want.row, want.col, want.lo, want.hi, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = med3_pkg::SIZE_RESET;
            height_reg = med3_pkg::SIZE_RESET;
            row_pos    = 0;
            col_pos    = 0;
            for (int k = 0; k < 9; k++)
                win[k] = '0;
            for (int k = 0; k < 2*SIDE_MAX; k++)
                line_mem[k] = '0;
            minmax_due.delete();
            words_due <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    med3_pkg::REG_FRAME_WIDTH:  width_reg  = cfg.data;
                    med3_pkg::REG_FRAME_HEIGHT: height_reg = cfg.data;
                    default: ;
                endcase
            end
            if (pixel.valid && pixel.ready)
                take_pixel(pixel.pixel_value);
            if (result.valid && result.ready)
                check_word();
            words_due <= minmax_due.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int SIDE_MAX      = 1024;
    localparam int TOTAL_PIXELS  = 180;
    localparam int CLOSE_PIXELS  = 36;
    localparam int FRAME_CAP     = 40;

    logic clk = 1'b0;
    logic rst_n;

    med3_pix_if pix_ch ();
    med3_res_if res_ch ();
    med3_cfg_if cfg_ch ();

    int   fail_count;
    int   words_due;
    int   words_checked;

    logic calm;
    logic hold_req;
    logic long_hold;
    int   tx_rate;
    int   rx_rate      = 0;
    int   rx_stall     = 0;
    int   rx_mode_left = 0;
    int   cycle_count  = 0;
    int   eff_w;
    int   eff_h;
    int   pixels_sent  = 0;
    int   frames_sent  = 0;

    morph_erode_dilate_3x3 i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    minmax_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pix_ch),
        .result        (res_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL morph_erode_dilate_3x3");
            $finish;
        end
    end

    // Result side: stall bursts whose rate is picked anew each time the mode counter runs out, plus one long hold.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode_left = 40;
            case ($urandom_range(0, 2))
                0:       rx_rate = 0;
                1:       rx_rate = 3;
                default: rx_rate = 10;
            endcase
        end
        else
        begin
            rx_mode_left--;
        end

        if (!rst_n || long_hold)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            res_ch.ready <= 1'b0;
            rx_stall--;
        end
        else if (!calm && rx_rate != 0 && $urandom_range(0, rx_rate) == 0)
        begin
            rx_stall = $urandom_range(1, 12) - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        long_hold = 1'b0;
        wait (hold_req == 1'b1);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    function automatic int eff_size(input int v);
        if (v < 1)
            return 1;
        if (v > SIDE_MAX)
            return SIDE_MAX;
        return v;
    endfunction

    function automatic logic [med3_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return med3_pkg::PIX_W'($urandom_range(0, 15));
            default: return med3_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [med3_pkg::PIX_W-1:0] v);
        if (!calm && tx_rate != 0 && $urandom_range(0, tx_rate) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= v;
        do @(posedge clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        // pixels that complete no word may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [med3_pkg::CFG_W-1:0] w,
                               input logic [med3_pkg::CFG_W-1:0] h);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= med3_pkg::REG_FRAME_WIDTH;
        cfg_ch.data  <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= med3_pkg::REG_FRAME_HEIGHT;
        cfg_ch.data  <= h;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        eff_w = eff_size(int'(w));
        eff_h = eff_size(int'(h));
    endtask

    // One whole frame of random pixels; optionally stops mid-frame until all words are back.
    task automatic send_frame(input int pause_at);
        for (int k = 0; k < eff_w * eff_h; k++)
        begin
            if (k == pause_at)
            begin
                pix_ch.valid <= 1'b0;
                do @(posedge clk); while (words_due != 0);
            end
            send_pixel(pick_pixel());
        end
        frames_sent++;
    endtask

    initial
    begin
        logic [med3_pkg::PIX_W-1:0] mark_px [9];
        int                         w_val;
        int                         h_val;
        int                         h_cap;
        int                         nframes;

        mark_px = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h7FFF,
                    16'h8000, 16'hFFFE, 16'h1234, 16'h0000};

        rst_n              = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = med3_pkg::REG_FRAME_WIDTH;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        tx_rate            = 3;
        eff_w              = int'(med3_pkg::SIZE_RESET);
        eff_h              = int'(med3_pkg::SIZE_RESET);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: corners, edges and single set bits in a 5x5 frame
        for (int k = 0; k < eff_w * eff_h; k++)
            send_pixel(k < 9 ? mark_px[k] : (med3_pkg::PIX_W'(1) << (k - 9)));
        frames_sent++;

        // zero sizes clamp to a single pixel frame
        write_sizes('0, '0);
        repeat (3) send_frame(-1);

        // one long row, then one tall column
        tx_rate = 0;
        write_sizes(11'd12, 11'd1);
        send_frame(-1);
        write_sizes(11'd1, 11'd12);
        send_frame(-1);

        // long output hold while the source keeps pushing, then a mid-frame drain
        write_sizes(11'd5, 11'd4);
        hold_req <= 1'b1;
        send_frame(-1);
        tx_rate = 3;
        send_frame(10);

        while (pixels_sent + CLOSE_PIXELS < TOTAL_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:       w_val = 0;
                1:       w_val = $urandom_range(9, 12);
                default: w_val = $urandom_range(1, 8);
            endcase
            h_cap = FRAME_CAP / eff_size(w_val);
            if (h_cap > 8)
                h_cap = 8;
            if ($urandom_range(0, 9) == 0)
                h_val = 0;
            else
                h_val = $urandom_range(1, h_cap);
            case ($urandom_range(0, 2))
                0:       tx_rate = 0;
                1:       tx_rate = 2;
                default: tx_rate = 6;
            endcase
            write_sizes(med3_pkg::CFG_W'(w_val), med3_pkg::CFG_W'(h_val));
            nframes = $urandom_range(1, 2);
            repeat (nframes)
            begin
                if (pixels_sent + CLOSE_PIXELS < TOTAL_PIXELS)
                begin
                    if (eff_w * eff_h > 1 && $urandom_range(0, 4) == 0)
                        send_frame($urandom_range(1, eff_w * eff_h - 1));
                    else
                        send_frame(-1);
                end
            end
        end

        // closing frame at full rate on both sides
        calm <= 1'b1;
        write_sizes(11'd9, 11'd4);
        send_frame(-1);

        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (20) @(posedge clk);

        $display("Run covered %0d frames, %0d pixels, %0d min/max words checked;",
                 frames_sent, pixels_sent, words_checked);
        $display("sizes from 1x1 to 12 wide or tall, zero sizes, random stalls, one long hold.");
        if (fail_count == 0)
            $display("PASS morph_erode_dilate_3x3");
        else
            $display("FAIL morph_erode_dilate_3x3");
        $finish;
    end

endmodule
